/* hdl/rsc_pkg.sv */
// ----------------------------------------------------------------------------
// RPN calculator package
// Shared sizes, token and status codes, control structs and the sequencer
// state type of the reverse Polish notation stack calculator.
// ----------------------------------------------------------------------------
package rsc_pkg;

   // Stack size and derived widths.
   localparam int STACK_DEPTH = 16;
   localparam int DATA_W      = 32;
   localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int STEP_W      = $clog2(DATA_W);
   localparam int MODE_W      = 3;
   localparam int DEPTH_W     = 5;
   localparam int STATUS_W    = 2;

   // Token kinds.
   localparam logic [MODE_W-1:0] MODE_PUSH = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ADD  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SUB  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_MUL  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DIV  = 3'd4;

   // Status codes.
   localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STS_UNDER   = 2'd1;
   localparam logic [STATUS_W-1:0] STS_OVER    = 2'd2;
   localparam logic [STATUS_W-1:0] STS_DIVZERO = 2'd3;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctrl_type;

   typedef struct packed {
      logic              push;
      logic              replace;
      logic [DATA_W-1:0] value;
   } stack_cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0]  count;
      logic [DATA_W-1:0] top;
      logic [DATA_W-1:0] second;
   } stack_view_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_CALC,
      ST_COMMIT,
      ST_REPLY
   } state_type;

   // Maps an operator token onto the serial unit's operation.
   function automatic alu_op_type mode_to_op(input logic [MODE_W-1:0] mode);
      alu_op_type op;
      unique case (mode)
         MODE_SUB: op = ALU_SUB;
         MODE_MUL: op = ALU_MUL;
         MODE_DIV: op = ALU_DIV;
         default:  op = ALU_ADD;
      endcase
      return op;
   endfunction

endpackage

/* hdl/rsc_stack.sv */
// ----------------------------------------------------------------------------
// RPN calculator operand stack
// Operand memory with one write port and one registered read port, the
// entry count and a copy of the top entry.
// ----------------------------------------------------------------------------
module rsc_stack (
   input  logic                   clock,
   input  logic                   reset,
   input  rsc_pkg::stack_cmd_type cmd,
   output rsc_pkg::stack_view_type view
);
   import rsc_pkg::*;

   logic [DATA_W-1:0] mem [STACK_DEPTH];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0] top_ff, top_in;
   logic [DATA_W-1:0] rd_data_ff;
   logic [CNT_W-1:0]  below_top;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;

   // The entry under the top is always the one read.
   assign below_top = count_ff - CNT_W'(2);
   assign rd_addr   = below_top[ADDR_W-1:0];

   // A push writes above the top, a replace overwrites the entry under it.
   assign wr_addr = cmd.push ? count_ff[ADDR_W-1:0] : rd_addr;

   always_comb begin
      count_in = count_ff;
      top_in   = top_ff;
      if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
         top_in   = cmd.value;
      end else if (cmd.replace) begin
         count_in = count_ff - CNT_W'(1);
         top_in   = cmd.value;
      end
   end

   // Memory write and registered read.
   always_ff @(posedge clock) begin
      if (cmd.push || cmd.replace) begin
         mem[wr_addr] <= cmd.value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      top_ff <= top_in;
   end

   assign view.count  = count_ff;
   assign view.top    = top_ff;
   assign view.second = rd_data_ff;

endmodule

/* hdl/rsc_alu.sv */
// ----------------------------------------------------------------------------
// RPN calculator serial arithmetic unit
// Works one operand bit per cycle: bit-serial add and subtract, shift-add
// multiply and restoring divide on magnitudes with a final sign fix.
// ----------------------------------------------------------------------------
module rsc_alu (
   input  logic                          clock,
   input  logic                          reset,
   input  rsc_pkg::alu_ctrl_type         ctrl,
   input  logic [rsc_pkg::DATA_W-1:0]    x,
   input  logic [rsc_pkg::DATA_W-1:0]    y,
   output logic                          done,
   output logic [rsc_pkg::DATA_W-1:0]    result
);
   import rsc_pkg::*;

   logic              busy_ff, busy_in;
   logic              fin_ff, fin_in;
   logic              done_ff;
   alu_op_type        op_ff, op_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DATA_W-1:0] a_ff, a_in;
   logic [DATA_W-1:0] b_ff, b_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic              carry_ff, carry_in;
   logic              neg_ff, neg_in;
   logic [DATA_W-1:0] result_ff;
   logic              sum_bit;
   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   trial;

   assign sum_bit = a_ff[0] ^ b_ff[0] ^ carry_ff;
   assign shifted = {acc_ff, a_ff[DATA_W-1]};
   assign trial   = shifted - {1'b0, b_ff};

   // One iteration per cycle while busy.
   always_comb begin
      busy_in  = busy_ff;
      fin_in   = 1'b0;
      op_in    = op_ff;
      step_in  = step_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      carry_in = carry_ff;
      neg_in   = neg_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         op_in   = ctrl.op;
         step_in = '0;
         acc_in  = '0;
         neg_in  = 1'b0;
         unique case (ctrl.op)
            ALU_ADD: begin
               a_in     = x;
               b_in     = y;
               carry_in = 1'b0;
            end
            ALU_SUB: begin
               a_in     = x;
               b_in     = ~y;
               carry_in = 1'b1;
            end
            ALU_MUL: begin
               a_in = x;
               b_in = y;
            end
            ALU_DIV: begin
               a_in   = x[DATA_W-1] ? -x : x;
               b_in   = y[DATA_W-1] ? -y : y;
               neg_in = x[DATA_W-1] ^ y[DATA_W-1];
            end
            default: begin
               a_in = x;
               b_in = y;
            end
         endcase
      end else if (busy_ff) begin
         unique case (op_ff)
            ALU_ADD, ALU_SUB: begin
               // Sum bits enter the accumulator from the top.
               acc_in   = {sum_bit, acc_ff[DATA_W-1:1]};
               carry_in = (a_ff[0] & b_ff[0]) | (carry_ff & (a_ff[0] ^ b_ff[0]));
               a_in     = a_ff >> 1;
               b_in     = b_ff >> 1;
            end
            ALU_MUL: begin
               if (b_ff[0]) begin
                  acc_in = acc_ff + a_ff;
               end
               a_in = a_ff << 1;
               b_in = b_ff >> 1;
            end
            ALU_DIV: begin
               // Dividend bits leave a from the top, quotient bits enter below.
               if (!trial[DATA_W]) begin
                  acc_in = trial[DATA_W-1:0];
                  a_in   = {a_ff[DATA_W-2:0], 1'b1};
               end else begin
                  acc_in = shifted[DATA_W-1:0];
                  a_in   = {a_ff[DATA_W-2:0], 1'b0};
               end
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= fin_ff;
      end
      op_ff    <= op_in;
      step_ff  <= step_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      acc_ff   <= acc_in;
      carry_ff <= carry_in;
      neg_ff   <= neg_in;
   end

   // Final cycle picks the result and applies the quotient sign.
   always_ff @(posedge clock) begin
      if (fin_ff) begin
         if (op_ff == ALU_DIV) begin
            result_ff <= neg_ff ? -a_ff : a_ff;
         end else begin
            result_ff <= acc_ff;
         end
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

/* hdl/rpn_stack_calculator.sv */
// ----------------------------------------------------------------------------
// RPN stack calculator
// Evaluates reverse Polish notation tokens on a bounded operand stack and
// returns top of stack, depth and status for every token.
// ----------------------------------------------------------------------------
// One token is in work at a time. A push, an unused mode or a token that
// ends in underflow, overflow or divide by zero goes from the transfer to
// the reply state, which loads the result register once it is free. An
// operator that runs goes through the load state, which starts the
// bit-serial arithmetic unit on the entry under the top that the transfer
// edge reads from memory, the calculate state, in which the unit works one
// operand bit per cycle, then finishes and signs the result, the commit
// state, which writes it back, and the reply state. The next token can be
// taken once the result is in the result register, even while that result
// still waits for its transfer. Faulting tokens leave the stack unchanged;
// the top value reads zero when the stack is empty.
module rpn_stack_calculator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [rsc_pkg::MODE_W-1:0]      req_mode,
   input  logic signed [rsc_pkg::DATA_W-1:0] req_number,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [rsc_pkg::DATA_W-1:0] rsp_top_value,
   output logic [rsc_pkg::DEPTH_W-1:0]     rsp_depth,
   output logic [rsc_pkg::STATUS_W-1:0]    rsp_status
);
   import rsc_pkg::*;

   state_type           state_ff, state_in;
   alu_op_type          op_ff, op_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_top_ff, rsp_top_in;
   logic [DEPTH_W-1:0]  rsp_depth_ff, rsp_depth_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                accept;
   logic                run_op;
   logic                push_ok;
   logic                rsp_load;
   stack_cmd_type       stack_cmd;
   stack_view_type      view;
   alu_ctrl_type        alu_ctrl;
   logic                alu_done;
   logic [DATA_W-1:0]   alu_result;

   rsc_stack u_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (stack_cmd),
      .view  (view)
   );

   rsc_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (alu_ctrl),
      .x      (view.second),
      .y      (view.top),
      .done   (alu_done),
      .result (alu_result)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Token decode: status of the token and whether it goes to the unit.
   always_comb begin
      status_in = status_ff;
      op_in     = op_ff;
      run_op    = 1'b0;
      push_ok   = 1'b0;
      if (accept) begin
         status_in = STS_OK;
         op_in     = mode_to_op(req_mode);
         unique case (req_mode)
            MODE_PUSH: begin
               if (view.count == CNT_W'(STACK_DEPTH)) begin
                  status_in = STS_OVER;
               end else begin
                  push_ok = 1'b1;
               end
            end
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
               priority if (view.count < CNT_W'(2)) begin
                  status_in = STS_UNDER;
               end else if (req_mode == MODE_DIV && view.top == '0) begin
                  status_in = STS_DIVZERO;
               end else begin
                  run_op = 1'b1;
               end
            end
            default: begin
               status_in = STS_OK;
            end
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = run_op ? ST_LOAD : ST_REPLY;
            end
         end
         ST_LOAD:   state_in = ST_CALC;
         ST_CALC: begin
            if (alu_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: state_in = ST_REPLY;
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: stack writes, unit start, result load.
   always_comb begin
      stack_cmd.push    = 1'b0;
      stack_cmd.replace = 1'b0;
      stack_cmd.value   = req_number;
      alu_ctrl.start    = 1'b0;
      alu_ctrl.op       = op_ff;
      rsp_load          = 1'b0;
      unique case (state_ff)
         ST_IDLE:   stack_cmd.push = push_ok;
         ST_LOAD:   alu_ctrl.start = 1'b1;
         ST_CALC:   alu_ctrl.start = 1'b0;
         ST_COMMIT: begin
            stack_cmd.replace = 1'b1;
            stack_cmd.value   = alu_result;
         end
         ST_REPLY:  rsp_load = !rsp_valid_ff || rsp_ready;
         default:   rsp_load = 1'b0;
      endcase
   end

   // Result register parts the result channel from the sequencer.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_top_in    = (view.count == '0) ? '0 : view.top;
         rsp_depth_in  = DEPTH_W'(view.count);
         rsp_status_in = status_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      status_ff     <= status_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_top_value = rsp_top_ff;
   assign rsp_depth     = rsp_depth_ff;
   assign rsp_status    = rsp_status_ff;

   // The entry count never passes the stack size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      view.count <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond stack size");

   // The arithmetic unit only finishes while the sequencer waits for it.
   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      alu_done |-> state_ff == ST_CALC)
      else $error("arithmetic result outside the calculate state");

   // A write-back pops exactly one entry.
   a_commit_pops: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COMMIT |=> view.count == $past(view.count) - CNT_W'(1))
      else $error("write-back did not pop one entry");

   // An underflow is reported only with fewer than two entries.
   a_under_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_load && status_ff == STS_UNDER |-> view.count < CNT_W'(2))
      else $error("underflow reported with two or more entries");

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// RPN stack calculator testbench
// Sends push and operator tokens to the calculator through bursts of random
// length and checks every top of stack, depth and status against a predictor
// that keeps its own copy of the operand stack. The directed tests cover
// underflow, overflow, divide by zero, wrapping arithmetic and unused modes.
// A long random test with a shifting push bias follows.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rsc_pkg::*;

   // Unused token kinds; the calculator answers them without changing the stack.
   localparam int MODE_SPARE_FIRST = 5;
   localparam int MODE_SPARE_LAST  = 7;

   localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
   localparam logic [DATA_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] WORD_NEG_ONE = 32'hFFFF_FFFF;

   localparam int RANDOM_TOKENS = 1400;
   localparam int SETTLE_CYCLES = 48;

   typedef struct packed {
      logic [DATA_W-1:0]   top_value;
      logic [DEPTH_W-1:0]  depth;
      logic [STATUS_W-1:0] status;
   } calc_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [MODE_W-1:0]          req_mode = MODE_PUSH;
   logic signed [DATA_W-1:0]   req_number = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [DATA_W-1:0]   rsp_top_value;
   logic [DEPTH_W-1:0]         rsp_depth;
   logic [STATUS_W-1:0]        rsp_status;

   // Predictor state: a private copy of the operand stack.
   logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
   int unsigned       shadow_count = 0;

   calc_result_type expected_results[$];
   int              error_count = 0;
   int              burst_left = 0;

   rpn_stack_calculator dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_number    (req_number),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_top_value (rsp_top_value),
      .rsp_depth     (rsp_depth),
      .rsp_status    (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one token to the shadow stack and returns the result it causes.
   function automatic calc_result_type evaluate_token(input logic [MODE_W-1:0] mode,
                                                      input logic [DATA_W-1:0] number);
      calc_result_type res;
      logic [DATA_W-1:0] lower, upper, value, lower_mag, upper_mag, quotient;
      logic              commit;
      res.status = STS_OK;
      commit = 1'b1;
      value = '0;
      case (mode)
         MODE_PUSH: begin
            if (shadow_count >= STACK_DEPTH) begin
               res.status = STS_OVER;
            end else begin
               shadow_stack[shadow_count] = number;
               shadow_count++;
            end
         end
         MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
            if (shadow_count < 2) begin
               res.status = STS_UNDER;
            end else begin
               upper = shadow_stack[shadow_count-1];
               lower = shadow_stack[shadow_count-2];
               case (mode)
                  MODE_ADD: value = lower + upper;
                  MODE_SUB: value = lower - upper;
                  MODE_MUL: value = lower * upper;
                  default: begin
                     if (upper == '0) begin
                        commit = 1'b0;
                        res.status = STS_DIVZERO;
                     end else begin
                        // Divide magnitudes, then apply the sign: truncates toward zero.
                        lower_mag = lower[DATA_W-1] ? -lower : lower;
                        upper_mag = upper[DATA_W-1] ? -upper : upper;
                        quotient = lower_mag / upper_mag;
                        value = (lower[DATA_W-1] ^ upper[DATA_W-1]) ? -quotient : quotient;
                     end
                  end
               endcase
               if (commit) begin
                  shadow_count--;
                  shadow_stack[shadow_count-1] = value;
               end
            end
         end
         default: ;
      endcase
      res.top_value = (shadow_count > 0) ? shadow_stack[shadow_count-1] : '0;
      res.depth = DEPTH_W'(shadow_count);
      return res;
   endfunction

   // Operand mix: small values hit zero divisors often, extremes hit wrapping.
   function automatic logic [DATA_W-1:0] pick_operand();
      logic [DATA_W-1:0] pick;
      int unsigned       roll;
      roll = $urandom_range(99);
      if (roll < 30) begin
         pick = DATA_W'($signed($urandom_range(16)) - 8);
      end else if (roll < 40) begin
         case ($urandom_range(4))
            0: pick = WORD_MIN;
            1: pick = WORD_MAX;
            2: pick = WORD_NEG_ONE;
            3: pick = '0;
            default: pick = 32'd1;
         endcase
      end else begin
         pick = $urandom;
      end
      return pick;
   endfunction

   // Sends one token, with a random gap between bursts, and records the
   // expected result once the transfer has happened.
   task automatic send_token(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] number);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid  <= 1'b1;
      req_mode   <= mode;
      req_number <= number;
      do @(posedge clock); while (!req_ready);
      expected_results.push_back(evaluate_token(mode, number));
   endtask

   // Operators on an empty stack and on a single entry.
   task automatic test_underflow();
      send_token(MODE_ADD, $urandom);
      send_token(MODE_PUSH, WORD_MIN);
      send_token(MODE_DIV, $urandom);
   endtask

   // Fills the stack to the brim, then pushes once more. The top entries are
   // laid out for the operator test that follows.
   task automatic test_overflow();
      logic [DATA_W-1:0] fill [15];
      fill = '{WORD_MAX, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, -32'sd2, 32'd100,
               -32'sd100, 32'h0001_0001, 32'h0001_0001, WORD_MIN, WORD_MIN, WORD_NEG_ONE};
      foreach (fill[i]) send_token(MODE_PUSH, fill[i]);
      send_token(MODE_PUSH, 32'h1234_5678);
   endtask

   // Most negative over minus one, wrapping add, divide by zero, subtract, wrapping
   // multiply and a negative quotient that truncates toward zero.
   task automatic test_operators();
      send_token(MODE_DIV, $urandom);
      send_token(MODE_ADD, $urandom);
      send_token(MODE_DIV, $urandom);
      send_token(MODE_SUB, $urandom);
      send_token(MODE_MUL, $urandom);
      send_token(MODE_PUSH, -32'sd7);
      send_token(MODE_PUSH, 32'd2);
      send_token(MODE_DIV, $urandom);
   endtask

   task automatic test_unused_modes();
      for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++) begin
         send_token(MODE_W'(m), $urandom);
      end
   endtask

   // Random token stream in segments, each with its own push bias, so the
   // depth wanders from empty to full.
   task automatic test_random();
      int unsigned       push_pct;
      int                segment_left;
      int unsigned       roll;
      logic [MODE_W-1:0] mode;
      segment_left = 0;
      push_pct = 50;
      for (int n = 0; n < RANDOM_TOKENS; n++) begin
         if (segment_left == 0) begin
            segment_left = $urandom_range(10, 60);
            push_pct = $urandom_range(20, 80);
         end
         segment_left--;
         roll = $urandom_range(99);
         if (roll < 4) begin
            mode = MODE_W'(MODE_SPARE_FIRST + $urandom_range(MODE_SPARE_LAST - MODE_SPARE_FIRST));
         end else if (roll < push_pct) begin
            mode = MODE_PUSH;
         end else begin
            case ($urandom_range(3))
               0: mode = MODE_ADD;
               1: mode = MODE_SUB;
               2: mode = MODE_MUL;
               default: mode = MODE_DIV;
            endcase
         end
         send_token(mode, pick_operand());
      end
   endtask

   // Receiver stall pattern: a new style is picked whenever the low byte of the cycle counter is zero.
   int unsigned stall_style = 0;
   int unsigned stall_cycle = 0;
   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 1;
      if (stall_cycle[7:0] == 8'd0) begin
         stall_style <= $urandom_range(3);
      end
      case (stall_style)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(1));
         2: rsp_ready <= (stall_cycle[1:0] == 2'd3);
         default: rsp_ready <= ($urandom_range(3) != 0);
      endcase
   end

   // Compares every result transfer with the oldest expectation.
   always @(posedge clock) begin
      calc_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result top_value %h depth %0d status %0d",
                     $time, rsp_top_value, rsp_depth, rsp_status);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_top_value !== want.top_value) begin
               $display("%0t: top_value expected %h actual %h",
                        $time, want.top_value, rsp_top_value);
               error_count++;
            end
            if (rsp_depth !== want.depth) begin
               $display("%0t: depth expected %0d actual %0d", $time, want.depth, rsp_depth);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_underflow();
      test_overflow();
      test_operators();
      test_unused_modes();
      test_random();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Hang guard, far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
